// ===== rtl/htfd_pkg.sv =====
// shared types, constants and the crc-8 step for the humidity/temperature frame decoder
// no dependencies; imported by htfd_frame, htfd_conv and the top level
package htfd_pkg;

   localparam logic [7:0]  CRC_INIT    = 8'hFF;
   localparam logic [7:0]  CRC_POLY    = 8'h31;
   localparam logic [14:0] T_SCALE     = 15'd17500;
   localparam logic [14:0] H_SCALE     = 15'd10000;
   localparam logic [16:0] DIV_BASE    = 17'd65535;
   localparam logic [15:0] DIV5_RECIP  = 16'd52429;
   localparam logic [14:0] C_OFFSET    = 15'd4500;
   localparam logic [16:0] F_OFFSET    = 17'd4900;

   typedef enum logic [2:0] {
      POS_T_HI  = 3'd0,
      POS_T_LO  = 3'd1,
      POS_T_CRC = 3'd2,
      POS_H_HI  = 3'd3,
      POS_H_LO  = 3'd4,
      POS_H_CRC = 3'd5
   } pos_type;

   typedef struct packed {
      logic [15:0] raw_t;
      logic [15:0] raw_h;
      logic        crc_bad;
   } frame_type;

   function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
      end
      return c;
   endfunction

endpackage

// ===== rtl/htfd_frame.sv =====
// frame assembler: byte position, running crc-8 and raw word capture
// depends on htfd_pkg; flags the sixth byte and hands over the finished frame
module htfd_frame (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          data_byte,
   input  logic                frame_start,
   output logic                frame_done,
   output htfd_pkg::frame_type frame
);
   import htfd_pkg::*;

   pos_type     pos_ff, pos_in, pos_eff;
   logic [7:0]  crc_ff, crc_in, crc_eff;
   logic [15:0] raw_t_ff, raw_t_in;
   logic [7:0]  raw_hh_ff, raw_hh_in;
   logic [7:0]  raw_hl_ff, raw_hl_in;
   logic        t_bad_ff, t_bad_in;

   always_comb begin
      pos_eff = pos_ff;
      crc_eff = crc_ff;
      if (frame_start || (pos_ff > POS_H_CRC)) begin
         pos_eff = POS_T_HI;
         crc_eff = CRC_INIT;
      end
      pos_in     = pos_ff;
      crc_in     = crc_ff;
      raw_t_in   = raw_t_ff;
      raw_hh_in  = raw_hh_ff;
      raw_hl_in  = raw_hl_ff;
      t_bad_in   = t_bad_ff;
      frame_done = 1'b0;
      if (accept) begin
         case (pos_eff)
            POS_T_HI: begin
               raw_t_in[15:8] = data_byte;
               crc_in = crc8_next(crc_eff, data_byte);
               pos_in = POS_T_LO;
            end
            POS_T_LO: begin
               raw_t_in[7:0] = data_byte;
               crc_in = crc8_next(crc_eff, data_byte);
               pos_in = POS_T_CRC;
            end
            POS_T_CRC: begin
               t_bad_in = (crc_eff != data_byte);
               crc_in = CRC_INIT;
               pos_in = POS_H_HI;
            end
            POS_H_HI: begin
               raw_hh_in = data_byte;
               crc_in = crc8_next(crc_eff, data_byte);
               pos_in = POS_H_LO;
            end
            POS_H_LO: begin
               raw_hl_in = data_byte;
               crc_in = crc8_next(crc_eff, data_byte);
               pos_in = POS_H_CRC;
            end
            default: begin
               frame_done = 1'b1;
               crc_in = CRC_INIT;
               pos_in = POS_T_HI;
            end
         endcase
      end
      frame.raw_t   = raw_t_ff;
      frame.raw_h   = {raw_hh_ff, raw_hl_ff};
      frame.crc_bad = t_bad_ff || (crc_eff != data_byte);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_T_HI;
         crc_ff <= CRC_INIT;
      end else begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_t_ff  <= raw_t_in;
      raw_hh_ff <= raw_hh_in;
      raw_hl_ff <= raw_hl_in;
      t_bad_ff  <= t_bad_in;
   end

endmodule

// ===== rtl/htfd_conv.sv =====
// conversion datapath: raw words to centi-degrees and centi-percent in two register steps
// depends on htfd_pkg; load enables come from the flow control in the top level
module htfd_conv (
   input  logic                clock,
   input  logic                s1_load,
   input  htfd_pkg::frame_type frame,
   input  logic                s2_load,
   input  logic                out_load,
   output logic signed [14:0]  temperature_centi_c,
   output logic signed [15:0]  temperature_centi_f,
   output logic [13:0]         humidity_centi_pct,
   output logic                crc_error
);
   import htfd_pkg::*;

   frame_type s1_ff;
   logic [14:0] qt_ff, qt_in;
   logic [13:0] qh_ff, qh_in;
   logic        err_ff;
   logic [30:0] prod_t, prod_h, prod_5;
   logic [14:0] q0_t, q0_h, q_h, rem_full;
   logic [16:0] r_t, r_h;
   logic [11:0] qd;
   logic [2:0]  rem;
   logic [3:0]  frac;
   logic [15:0] nine_qd;
   logic signed [16:0] tf_full;
   logic signed [15:0] tc_full;
   logic signed [14:0] tc_ff;
   logic signed [15:0] tf_ff;
   logic [13:0] h_ff;
   logic        crc_error_ff;

   // divide by 65535: quotient from the high half, remainder fix with one compare
   always_comb begin
      prod_t = {15'd0, s1_ff.raw_t} * {16'd0, T_SCALE};
      prod_h = {15'd0, s1_ff.raw_h} * {16'd0, H_SCALE};
      q0_t   = prod_t[30:16];
      q0_h   = prod_h[30:16];
      r_t    = {1'b0, prod_t[15:0]} + {2'b00, q0_t};
      r_h    = {1'b0, prod_h[15:0]} + {2'b00, q0_h};
      qt_in  = q0_t + {14'd0, (r_t >= DIV_BASE)};
      q_h    = q0_h + {14'd0, (r_h >= DIV_BASE)};
      qh_in  = q_h[13:0];
   end

   // fahrenheit: 9*q/5 split as 9*(q/5) plus a small table on q mod 5
   always_comb begin
      prod_5   = {16'd0, qt_ff} * {15'd0, DIV5_RECIP};
      qd       = prod_5[29:18];
      rem_full = qt_ff - ({1'b0, qd, 2'b00} + {3'b000, qd});
      rem      = rem_full[2:0];
      if (qt_ff >= C_OFFSET) begin
         case (rem)
            3'd0:    frac = 4'd0;
            3'd1:    frac = 4'd1;
            3'd2:    frac = 4'd3;
            3'd3:    frac = 4'd5;
            3'd4:    frac = 4'd7;
            default: frac = 4'd0;
         endcase
      end else begin
         case (rem)
            3'd0:    frac = 4'd0;
            3'd1:    frac = 4'd2;
            3'd2:    frac = 4'd4;
            3'd3:    frac = 4'd6;
            3'd4:    frac = 4'd8;
            default: frac = 4'd0;
         endcase
      end
      nine_qd = {1'b0, qd, 3'b000} + {4'd0, qd};
      tf_full = $signed({1'b0, nine_qd + {12'd0, frac}}) - $signed(F_OFFSET);
      tc_full = $signed({1'b0, qt_ff}) - $signed({1'b0, C_OFFSET});
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_ff <= frame;
      end
      if (s2_load) begin
         qt_ff  <= qt_in;
         qh_ff  <= qh_in;
         err_ff <= s1_ff.crc_bad;
      end
      if (out_load) begin
         crc_error_ff <= err_ff;
         if (err_ff) begin
            tc_ff <= '0;
            tf_ff <= '0;
            h_ff  <= '0;
         end else begin
            tc_ff <= tc_full[14:0];
            tf_ff <= tf_full[15:0];
            h_ff  <= qh_ff;
         end
      end
   end

   assign temperature_centi_c = tc_ff;
   assign temperature_centi_f = tf_ff;
   assign humidity_centi_pct  = h_ff;
   assign crc_error           = crc_error_ff;

endmodule

// ===== rtl/humidity_temperature_frame_decoder_unit.sv =====
// top level of the humidity/temperature frame decoder: handshakes and stage flow control
// depends on htfd_pkg, htfd_frame and htfd_conv
//
//   port group  direction  contents
//   req_        in         data_byte, frame_start; one frame byte per request
//   rsp_        out        centi-c, centi-f, centi-pct, crc_error; one per six-byte frame
//
// one request per cycle unless req_stall; after its sixth byte, a frame's result passes
// through frame capture, divide-by-65535 step, fahrenheit step and output register
// synchronous reset returns the frame position to the first byte and empties the stages
// rsp_stall holds the output; requests keep flowing until all result stages are full
module humidity_temperature_frame_decoder_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_data_byte,
   input  logic               req_frame_start,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [14:0] rsp_temperature_centi_c,
   output logic signed [15:0] rsp_temperature_centi_f,
   output logic [13:0]        rsp_humidity_centi_pct,
   output logic               rsp_crc_error
);
   import htfd_pkg::*;

   logic      s1_valid_ff, s1_valid_in;
   logic      s2_valid_ff, s2_valid_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_ready, s2_ready, s1_ready;
   logic      accept, frame_done, s2_load, rsp_load;
   frame_type frame;

   always_comb begin
      rsp_ready    = !rsp_valid_ff || !rsp_stall;
      s2_ready     = !s2_valid_ff || rsp_ready;
      s1_ready     = !s1_valid_ff || s2_ready;
      req_stall    = !s1_ready;
      accept       = req_valid && s1_ready;
      s2_load      = s1_valid_ff && s2_ready;
      rsp_load     = s2_valid_ff && rsp_ready;
      s1_valid_in  = frame_done || (s1_valid_ff && !s2_ready);
      s2_valid_in  = s2_load || (s2_valid_ff && !rsp_ready);
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   htfd_frame u_frame (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_data_byte),
      .frame_start (req_frame_start),
      .frame_done  (frame_done),
      .frame       (frame)
   );

   htfd_conv u_conv (
      .clock               (clock),
      .s1_load             (frame_done),
      .frame               (frame),
      .s2_load             (s2_load),
      .out_load            (rsp_load),
      .temperature_centi_c (rsp_temperature_centi_c),
      .temperature_centi_f (rsp_temperature_centi_f),
      .humidity_centi_pct  (rsp_humidity_centi_pct),
      .crc_error           (rsp_crc_error)
   );

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/htfd_checker.sv =====
// port-level checks for the humidity/temperature frame decoder
// no package dependency; bound to humidity_temperature_frame_decoder_unit below
module htfd_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [14:0] rsp_temperature_centi_c,
   input logic signed [15:0] rsp_temperature_centi_f,
   input logic [13:0]        rsp_humidity_centi_pct,
   input logic               rsp_crc_error
);

   // reset empties the output
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // stalled request stays offered
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid)
      else $error("stalled request withdrawn");

   // held result stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_temperature_centi_c)
         && $stable(rsp_temperature_centi_f) && $stable(rsp_humidity_centi_pct)
         && $stable(rsp_crc_error))
      else $error("stalled result changed");

   // crc error zeroes the values
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_crc_error |-> rsp_temperature_centi_c == 15'sd0
         && rsp_temperature_centi_f == 16'sd0 && rsp_humidity_centi_pct == 14'd0)
      else $error("values not zero on crc error");

   // good frames stay in the sensor range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_crc_error |-> rsp_temperature_centi_c >= -15'sd4500
         && rsp_temperature_centi_c <= 15'sd13000 && rsp_humidity_centi_pct <= 14'd10000
         && rsp_temperature_centi_f >= -16'sd4900 && rsp_temperature_centi_f <= 16'sd26600)
      else $error("converted value out of range");

endmodule

bind humidity_temperature_frame_decoder_unit htfd_checker u_checker (.*);
